### rtl/core/psd_pkg.sv
// Shared types and constants for the point-to-segment distance unit.
// No dependencies.
package psd_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 4;
    localparam int RADIUS_WIDTH    = 16;
    localparam int RADIUS_RESET    = 16;
    localparam int REGION_WIDTH    = 2;

    localparam logic [REGION_WIDTH-1:0] REGION_START = 2'd0;
    localparam logic [REGION_WIDTH-1:0] REGION_END   = 2'd1;
    localparam logic [REGION_WIDTH-1:0] REGION_MID   = 2'd2;

    // Control that travels alongside each item through the cell chains
    typedef struct packed {
        logic                    valid;
        logic [REGION_WIDTH-1:0] region;
        logic                    hit;
    } t_ctl;

endpackage

### rtl/core/psd_front.sv
// Front pipeline: differences, products, sums, region select, squared cross.
// Depends on psd_pkg.
module psd_front
    import psd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int DW = COORD_WIDTH + 1,
    localparam int PW = 2 * DW,
    localparam int SW = PW + 1,
    localparam int QW = 2 * COORD_WIDTH + 2 + 2 * FRAC_BITS,
    localparam int NW = 2 * SW + 2 * FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output t_ctl                          o_ctl,
    output logic        [SW-1:0]          o_rem,
    output logic        [QW-1:0]          o_word,
    output logic        [SW-1:0]          o_div
);

    // the cross magnitude never exceeds 2 * (2^CW - 1)^2
    localparam int CMW = 2 * COORD_WIDTH + 1;

    logic                    r_va, r_vb, r_vc, r_vd;
    logic signed [DW-1:0]    r_dx, r_dy, r_vx, r_vy, r_wx, r_wy;
    logic signed [PW-1:0]    r_dxvx, r_dyvy, r_dxdx, r_dydy, r_dxvy, r_dyvx;
    logic signed [PW-1:0]    r_vxvx, r_vyvy, r_wxwx, r_wywy;
    logic signed [SW-1:0]    r_dot, r_len2, r_cross, r_d2s, r_d2e;
    logic [REGION_WIDTH-1:0] r_region;
    logic [CMW-1:0]          r_cmag;
    logic [SW-1:0]           r_len2u, r_d2;
    logic [REGION_WIDTH-1:0] n_region;
    logic [CMW-1:0]          n_cmag;
    logic [2*CMW-1:0]        n_c2;
    logic [NW-1:0]           n_num;
    t_ctl                    r_ctl;
    logic [SW-1:0]           r_rem, r_div;
    logic [QW-1:0]           r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
            r_vc  <= 1'b0;
            r_vd  <= 1'b0;
            r_ctl <= '0;
        end else begin
            r_va  <= i_valid;
            r_vb  <= r_va;
            r_vc  <= r_vb;
            r_vd  <= r_vc;
            r_ctl <= '{valid: r_vd, region: r_region, hit: 1'b0};
        end
    end

    always_comb begin
        if (r_dot <= 0) begin
            n_region = REGION_START;
        end else if (r_dot >= r_len2) begin
            n_region = REGION_END;
        end else begin
            n_region = REGION_MID;
        end
        if (r_cross < 0) begin
            n_cmag = CMW'($unsigned(-r_cross));
        end else begin
            n_cmag = CMW'($unsigned(r_cross));
        end
        n_c2   = (2*CMW)'(r_cmag) * (2*CMW)'(r_cmag);
        if (r_region == REGION_MID) begin
            n_num = NW'(n_c2) << (2 * FRAC_BITS);
        end else begin
            n_num = NW'(r_d2) << (2 * FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= DW'(i_end_x) - DW'(i_start_x);
        r_dy <= DW'(i_end_y) - DW'(i_start_y);
        r_vx <= DW'(i_query_x) - DW'(i_start_x);
        r_vy <= DW'(i_query_y) - DW'(i_start_y);
        r_wx <= DW'(i_query_x) - DW'(i_end_x);
        r_wy <= DW'(i_query_y) - DW'(i_end_y);

        r_dxvx <= PW'(r_dx) * PW'(r_vx);
        r_dyvy <= PW'(r_dy) * PW'(r_vy);
        r_dxdx <= PW'(r_dx) * PW'(r_dx);
        r_dydy <= PW'(r_dy) * PW'(r_dy);
        r_dxvy <= PW'(r_dx) * PW'(r_vy);
        r_dyvx <= PW'(r_dy) * PW'(r_vx);
        r_vxvx <= PW'(r_vx) * PW'(r_vx);
        r_vyvy <= PW'(r_vy) * PW'(r_vy);
        r_wxwx <= PW'(r_wx) * PW'(r_wx);
        r_wywy <= PW'(r_wy) * PW'(r_wy);

        r_dot   <= SW'(r_dxvx) + SW'(r_dyvy);
        r_len2  <= SW'(r_dxdx) + SW'(r_dydy);
        r_cross <= SW'(r_dxvy) - SW'(r_dyvx);
        r_d2s   <= SW'(r_vxvx) + SW'(r_vyvy);
        r_d2e   <= SW'(r_wxwx) + SW'(r_wywy);

        r_region <= n_region;
        r_cmag   <= n_cmag;
        r_len2u  <= $unsigned(r_len2);
        r_d2     <= (n_region == REGION_END) ? $unsigned(r_d2e) : $unsigned(r_d2s);

        // endpoint cases divide by one so every item takes the same chain
        r_rem  <= n_num[QW+SW-1:QW];
        r_word <= n_num[QW-1:0];
        r_div  <= (r_region == REGION_MID) ? r_len2u : SW'(1);
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_word = r_word;
    assign o_div  = r_div;

endmodule

### rtl/core/psd_div_cell.sv
// One restoring division step: one quotient bit per cell.
// Depends on psd_pkg.
module psd_div_cell
    import psd_pkg::*;
#(
    parameter int SW = 35,
    parameter int QW = 42
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [SW-1:0] i_rem,
    input  logic [QW-1:0] i_word,
    input  logic [SW-1:0] i_div,
    output t_ctl          o_ctl,
    output logic [SW-1:0] o_rem,
    output logic [QW-1:0] o_word,
    output logic [SW-1:0] o_div
);

    logic [SW:0]   shifted, diff;
    logic          take;
    t_ctl          r_ctl;
    logic [SW-1:0] r_rem, r_div;
    logic [QW-1:0] r_word;

    always_comb begin
        shifted = {i_rem, i_word[QW-1]};
        diff    = shifted - {1'b0, i_div};
        take    = shifted >= {1'b0, i_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // shift numerator bits out at the top, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        r_rem  <= take ? diff[SW-1:0] : shifted[SW-1:0];
        r_word <= {i_word[QW-2:0], take};
        r_div  <= i_div;
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_word = r_word;
    assign o_div  = r_div;

endmodule

### rtl/core/psd_sqrt_cell.sv
// One restoring square root step: one root bit per cell.
// Depends on psd_pkg.
module psd_sqrt_cell
    import psd_pkg::*;
#(
    parameter int RW = 21,
    localparam int QW = 2 * RW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [RW+1:0] i_rem,
    input  logic [RW-1:0] i_root,
    input  logic [QW-1:0] i_rad,
    output t_ctl          o_ctl,
    output logic [RW+1:0] o_rem,
    output logic [RW-1:0] o_root,
    output logic [QW-1:0] o_rad
);

    logic [RW+3:0] cur, trial, diff;
    logic          take;
    t_ctl          r_ctl;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [QW-1:0] r_rad;

    always_comb begin
        cur   = {i_rem, i_rad[QW-1:QW-2]};
        trial = {2'b00, i_root, 2'b01};
        diff  = cur - trial;
        take  = cur >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= take ? diff[RW+1:0] : cur[RW+1:0];
        r_root <= {i_root[RW-2:0], take};
        r_rad  <= {i_rad[QW-3:0], 2'b00};
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

### rtl/core/point_segment_distance_unit.sv
// Top level of the point-to-segment distance unit: front pipeline, divider
// cell chain, square root cell chain. Depends on psd_pkg and the psd_* cells.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  item in  | start, busy (always low)  | i_query_*, i_start_*, i_end_*
//  result   | o_valid strobe, one cycle | o_distance_q4, o_region, o_hit
//  config   | i_cfg_valid, o_cfg_ready  | i_cfg_data (hit radius)
//
// One item is taken every cycle; each result passes five front stages,
// one divider cell per quotient bit and one root cell per result bit.
// Reset is synchronous; the hit radius resets to 16 pixels.
// The pipeline never stalls since the receiver cannot hold results off.
module point_segment_distance_unit
    import psd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_WIDTH-1:0]     i_query_x,
    input  logic signed [COORD_WIDTH-1:0]     i_query_y,
    input  logic signed [COORD_WIDTH-1:0]     i_start_x,
    input  logic signed [COORD_WIDTH-1:0]     i_start_y,
    input  logic signed [COORD_WIDTH-1:0]     i_end_x,
    input  logic signed [COORD_WIDTH-1:0]     i_end_y,
    output logic                              o_valid,
    output logic [COORD_WIDTH+FRAC_BITS:0]    o_distance_q4,
    output logic [REGION_WIDTH-1:0]           o_region,
    output logic                              o_hit,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [RADIUS_WIDTH-1:0]           i_cfg_data
);

    localparam int SW   = 2 * (COORD_WIDTH + 1) + 1;
    localparam int QW   = 2 * COORD_WIDTH + 2 + 2 * FRAC_BITS;
    localparam int RW   = QW / 2;
    localparam int HW   = 2 * RADIUS_WIDTH + 2 * FRAC_BITS;
    localparam int CMPW = (QW > HW) ? QW : HW;

    logic [2*RADIUS_WIDTH-1:0] r_rad2;

    t_ctl          dctl  [QW+1];
    logic [SW-1:0] drem  [QW+1];
    logic [QW-1:0] dword [QW+1];
    logic [SW-1:0] ddiv  [QW+1];

    t_ctl          sctl  [RW+1];
    logic [RW+1:0] srem  [RW+1];
    logic [RW-1:0] sroot [RW+1];
    logic [QW-1:0] srad  [RW+1];

    // hold the squared radius so the compare needs no multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad2 <= (2*RADIUS_WIDTH)'(RADIUS_RESET * RADIUS_RESET);
        end else if (i_cfg_valid) begin
            r_rad2 <= (2*RADIUS_WIDTH)'(i_cfg_data) * (2*RADIUS_WIDTH)'(i_cfg_data);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    psd_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_query_x(i_query_x),
        .i_query_y(i_query_y),
        .i_start_x(i_start_x),
        .i_start_y(i_start_y),
        .i_end_x  (i_end_x),
        .i_end_y  (i_end_y),
        .o_ctl    (dctl[0]),
        .o_rem    (drem[0]),
        .o_word   (dword[0]),
        .o_div    (ddiv[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_div
        psd_div_cell #(
            .SW(SW),
            .QW(QW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (dctl[g]),
            .i_rem  (drem[g]),
            .i_word (dword[g]),
            .i_div  (ddiv[g]),
            .o_ctl  (dctl[g+1]),
            .o_rem  (drem[g+1]),
            .o_word (dword[g+1]),
            .o_div  (ddiv[g+1])
        );
    end

    // floor of the scaled squared distance against radius squared is exact
    assign sctl[0]  = '{valid:  dctl[QW].valid,
                        region: dctl[QW].region,
                        hit:    CMPW'(dword[QW]) < (CMPW'(r_rad2) << (2 * FRAC_BITS))};
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign srad[0]  = dword[QW];

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        psd_sqrt_cell #(
            .RW(RW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (sctl[g]),
            .i_rem  (srem[g]),
            .i_root (sroot[g]),
            .i_rad  (srad[g]),
            .o_ctl  (sctl[g+1]),
            .o_rem  (srem[g+1]),
            .o_root (sroot[g+1]),
            .o_rad  (srad[g+1])
        );
    end

    assign o_valid       = sctl[RW].valid;
    assign o_region      = sctl[RW].region;
    assign o_hit         = sctl[RW].hit;
    assign o_distance_q4 = sroot[RW];

endmodule
